FILE: design/assert_macros.svh
// Assertion helpers for the design files, included by the top-level unit.
// Each macro expects i_clk and i_rst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: design/dslr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dslr_pkg
// Shared types and constants of the delayed shot release limiter.
// ----------------------------------------------------------------------------
package dslr_pkg;

    localparam int ID_W      = 16;
    localparam int TIME_W    = 32;
    localparam int CFG_IDX_W = 1;

    // Item opcodes
    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_LATENCY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL    = 1'b1;

    typedef struct packed {
        logic push;      // append request at tail
        logic set_drop;  // add found the queue full
        logic capture;   // latch query time, clear drop flag
        logic pop;       // retire head entry
        logic load_out;  // load the result register
    } t_dp_cmd;

    typedef struct packed {
        logic full;
        logic empty;
        logic head_due;  // head entry's release time has passed
        logic head_ok;   // head entry is far enough after the accepted shot
    } t_dp_stat;

endpackage

FILE: design/dslr_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dslr_req_if
// Request channel: add or query items.
// ----------------------------------------------------------------------------
interface dslr_req_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [15:0] shot_id;
    logic [31:0] time_us;

    modport source (output valid, output opcode, output shot_id, output time_us,
                    input ready);
    modport sink   (input valid, input opcode, input shot_id, input time_us,
                    output ready);
endinterface

FILE: design/dslr_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dslr_rsp_if
// Response channel: one result per request.
// ----------------------------------------------------------------------------
interface dslr_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] last_shot_id;
    logic        add_dropped;

    modport source (output valid, output last_shot_id, output add_dropped, input ready);
    modport sink   (input valid, input last_shot_id, input add_dropped, output ready);
endinterface

FILE: design/dslr_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dslr_cfg_if
// Configuration write channel.
// ----------------------------------------------------------------------------
interface dslr_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/delayed_shot_release_limiter_unit.sv
`timescale 1ns / 1ps
// One item at a time. An add pushes its entry (or sets the drop flag when full); a query
// captures its time and pops each due entry in S_EVAL (0 to QUEUE_DEPTH of them). Both
// load the result in S_DONE, which waits while the last response is not yet taken.
// The pop loop retires one entry per cycle through the FIFO memory's single read port.
// Reset (i_rst_n low, synchronous) empties the queue, zeroes the accepted shot and both
// config registers; FIFO storage is not cleared.
// ----------------------------------------------------------------------------
// delayed_shot_release_limiter_unit
// Queues shot requests and releases them after a delay, rate-limited.
// ----------------------------------------------------------------------------
module delayed_shot_release_limiter_unit #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dslr_req_if.sink    i_req,
    dslr_rsp_if.source  o_rsp,
    dslr_cfg_if.sink    i_cfg
);
    import dslr_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    assign i_cfg.ready = 1'b1;

    dslr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .i_opcode    (i_req.opcode),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    dslr_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_shot_id      (i_req.shot_id),
        .i_time_us      (i_req.time_us),
        .i_cfg_we       (i_cfg.valid),
        .i_cfg_index    (i_cfg.index),
        .i_cfg_data     (i_cfg.data),
        .o_last_shot_id (o_rsp.last_shot_id),
        .o_add_dropped  (o_rsp.add_dropped)
    );

`include "assert_macros.svh"

    `ASSERT_ALWAYS(a_full_xor_empty, !(w_stat.full && w_stat.empty), "queue both full and empty")
    `ASSERT_SAME(a_push_not_full, w_cmd.push, !w_stat.full, "push into a full queue")
    `ASSERT_SAME(a_pop_due, w_cmd.pop, !w_stat.empty && w_stat.head_due, "pop of a held entry")
    `ASSERT_SAME(a_one_op, w_cmd.push || w_cmd.set_drop, !w_cmd.pop && !w_cmd.capture, "overlap")

endmodule

FILE: design/dslr_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dslr_datapath
// Request FIFO memory, pointers, accepted shot, config and result registers.
// ----------------------------------------------------------------------------
module dslr_datapath #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  dslr_pkg::t_dp_cmd                          i_cmd,
    output dslr_pkg::t_dp_stat                         o_stat,
    input  logic [dslr_pkg::ID_W-1:0]                  i_shot_id,
    input  logic [dslr_pkg::TIME_W-1:0]                i_time_us,
    input  logic                                       i_cfg_we,
    input  logic [dslr_pkg::CFG_IDX_W-1:0]             i_cfg_index,
    input  logic [dslr_pkg::TIME_W-1:0]                i_cfg_data,
    output logic [dslr_pkg::ID_W-1:0]                  o_last_shot_id,
    output logic                                       o_add_dropped
);
    import dslr_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(QUEUE_DEPTH - 1);

    logic [ID_W-1:0]   mem_id   [QUEUE_DEPTH];
    logic [TIME_W-1:0] mem_time [QUEUE_DEPTH];

    logic [PTR_W-1:0]  r_head, n_head, r_tail, n_tail, w_rd_addr;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [ID_W-1:0]   r_rd_id, r_acc_id, r_out_id;
    logic [TIME_W-1:0] r_rd_time, r_acc_time, r_qtime;
    logic [TIME_W-1:0] r_latency, r_interval;
    logic              r_drop, r_out_drop;
    logic [TIME_W:0]   w_release_at, w_earliest;

    assign n_head = (r_head == LAST_IDX) ? '0 : r_head + PTR_W'(1);
    assign n_tail = (r_tail == LAST_IDX) ? '0 : r_tail + PTR_W'(1);
    // Read ahead to the next head while popping so one entry retires per cycle
    assign w_rd_addr = i_cmd.pop ? n_head : r_head;

    always_comb begin
        n_count = r_count;
        if (i_cmd.push) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_cmd.pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            mem_id[r_tail]   <= i_shot_id;
            mem_time[r_tail] <= i_time_us;
        end
        r_rd_id   <= mem_id[w_rd_addr];
        r_rd_time <= mem_time[w_rd_addr];
    end

    // 33-bit sums never wrap
    assign w_release_at = {1'b0, r_rd_time} + {1'b0, r_latency};
    assign w_earliest   = {1'b0, r_acc_time} + {1'b0, r_interval};

    assign o_stat.full     = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_stat.empty    = (r_count == '0);
    assign o_stat.head_due = ({1'b0, r_qtime} >= w_release_at);
    assign o_stat.head_ok  = ({1'b0, r_rd_time} >= w_earliest);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= '0;
            r_tail     <= '0;
            r_count    <= '0;
            r_acc_id   <= '0;
            r_acc_time <= '0;
            r_latency  <= '0;
            r_interval <= '0;
        end else begin
            r_count <= n_count;
            if (i_cmd.push) begin
                r_tail <= n_tail;
            end
            if (i_cmd.pop) begin
                r_head <= n_head;
                if (o_stat.head_ok) begin
                    r_acc_id   <= r_rd_id;
                    r_acc_time <= r_rd_time;
                end
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_RELEASE_LATENCY: r_latency  <= i_cfg_data;
                    CFG_MIN_INTERVAL:    r_interval <= i_cfg_data;
                    default:             r_latency  <= r_latency;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_qtime <= i_time_us;
            r_drop  <= 1'b0;
        end else if (i_cmd.push || i_cmd.set_drop) begin
            r_drop  <= i_cmd.set_drop;
        end
        if (i_cmd.load_out) begin
            r_out_id   <= r_acc_id;
            r_out_drop <= r_drop;
        end
    end

    assign o_last_shot_id = r_out_id;
    assign o_add_dropped  = r_out_drop;

endmodule

FILE: design/dslr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dslr_ctrl
// Sequencer: accepts one item, drives the pop loop, hands off the result.
// ----------------------------------------------------------------------------
module dslr_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_opcode,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  dslr_pkg::t_dp_stat i_stat,
    output dslr_pkg::t_dp_cmd  o_cmd
);
    import dslr_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;

    always_comb begin
        o_cmd       = '0;
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_opcode == OP_ADD) begin
                        o_cmd.push     = !i_stat.full;
                        o_cmd.set_drop = i_stat.full;
                        n_state        = S_DONE;
                    end else begin
                        o_cmd.capture = 1'b1;
                        n_state       = S_EVAL;
                    end
                end
            end
            S_EVAL: begin
                // Pop while the head is due; stop at the first one that is not
                if (!i_stat.empty && i_stat.head_due) begin
                    o_cmd.pop = 1'b1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule
